>>> sv/nrte_pkg.sv
// Shared types, constants and calendar helpers for the RMC time extractor.
package nrte_pkg;

	localparam int unsigned CHUNK_BYTES  = 2048;
	localparam int unsigned CNT_W        = $clog2(CHUNK_BYTES + 1);
	localparam int unsigned DATE_BACKOFF = 10;
	localparam logic [11:0] OFFSET_MAX   = 12'd4095;
	localparam logic [11:0] YEAR_BASE    = 12'd2000;
	localparam logic [11:0] EPOCH_YEAR   = 12'd1970;

	localparam logic [1:0] REG_ZONE   = 2'd0;
	localparam logic [1:0] REG_DRIFT  = 2'd1;
	localparam logic [1:0] REG_MINLEN = 2'd2;

	typedef enum logic [2:0] {
		ST_NONE    = 3'd0,
		ST_NOSTAR  = 3'd1,
		ST_BADSTAT = 3'd2,
		ST_SYNC    = 3'd3,
		ST_SET     = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MON,
		S_SEC,
		S_MIN,
		S_HR,
		S_BASE,
		S_WALK,
		S_MAC,
		S_CMP,
		S_DONE
	} state_t;

	// Digit character to 4-bit value, anything else to 15.
	function automatic logic [3:0] nib(input logic [7:0] c);
		return (c >= "0" && c <= "9") ? c[3:0] : 4'hF;
	endfunction

	// Expected character at each step of the "GPRMC" search.
	function automatic logic [7:0] pat_char(input logic [2:0] p);
		logic [7:0] r;
		case (p)
			3'd0:    r = "G";
			3'd1:    r = "P";
			3'd2:    r = "R";
			3'd3:    r = "M";
			default: r = "C";
		endcase
		return r;
	endfunction

	function automatic logic [6:0] pair_val(input logic [3:0] hi, input logic [3:0] lo);
		logic [6:0] r;
		if (hi > 4'd9)
			r = 7'd0;
		else if (lo > 4'd9)
			r = {3'b0, hi};
		else
			r = ({3'b0, hi} * 7'd10) + {3'b0, lo};
		return r;
	endfunction

	// Leap rule over the reachable years (1998..2110).
	function automatic logic is_leap(input logic [11:0] y);
		return (y[1:0] == 2'b00) && (y != 12'd2100);
	endfunction

	function automatic logic [4:0] dim(input logic [11:0] y, input logic [3:0] m);
		logic [4:0] r;
		case (m) inside
			4'd2:                    r = is_leap(y) ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
			default:                 r = 5'd31;
		endcase
		return r;
	endfunction

	// Days in the year before the first of month m.
	function automatic logic [8:0] cum_days(input logic [11:0] y, input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			default: r = 9'd334;
		endcase
		if (is_leap(y) && m > 4'd2)
			r = r + 9'd1;
		return r;
	endfunction

	// Day number of January 1 of year y, counted from the epoch.
	function automatic logic [16:0] jan1_days(input logic [11:0] y);
		logic [7:0] dy;
		logic [7:0] dl;
		logic [16:0] r;
		dy = 8'(y - EPOCH_YEAR);
		dl = 8'(y - (EPOCH_YEAR - 12'd1));
		r = (17'(dy) * 17'd365) + 17'(dl >> 2);
		if (y >= 12'd2101)
			r = r - 17'd1;
		return r;
	endfunction

endpackage

>>> sv/nmea_rmc_time_extractor_core.sv
// RMC time extractor: byte scanner, calendar sequencer and result register.
//
//  channel | direction | handshake         | word
//  --------+-----------+-------------------+-----------------------------------------
//  in      | input     | in_valid/in_stall | req_type, data_byte, now_seconds
//  out     | output    | out_valid/out_stall| status, led_lit, local date/time, flags
//  cfg     | input     | APB psel/penable  | zone, drift limit, min length at 0/4/8
//
// A byte word is taken while the sequencer is idle. An end-of-chunk word
// starts the sequencer: the shared compare/subtract unit folds months,
// seconds, minutes and hours, then the one-day walk over the calendar covers
// the day count from the date (0 to 103). A chunk that fails the length,
// star or position check goes straight to the result state. in_stall stays
// high while the sequencer runs and while its result waits for the output
// register. The result word sits in that register; bytes keep flowing meanwhile.
// Reset clears all control state and loads the register defaults.
module nmea_rmc_time_extractor_core
	import nrte_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [7:0]  data_byte,
	input  logic [31:0] now_seconds,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic        led_lit,
	output logic [11:0] local_year,
	output logic [3:0]  local_month,
	output logic [4:0]  local_day,
	output logic [4:0]  local_hour,
	output logic [5:0]  local_minute,
	output logic [5:0]  local_second,
	output logic        set_clock,
	output logic        save_hw_clock,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration registers
	logic [3:0] zone_q;
	logic [7:0] drift_q;
	logic [7:0] minlen_q;

	// per-chunk scan state
	logic [2:0]       prog_q;
	logic             found_q;
	logic [11:0]      off_q;
	logic [23:0]      tdig_q;
	logic [7:0]       stchar_q;
	logic [3:0]       tail_q [DATE_BACKOFF];
	logic             star_q;
	logic             pos_ok_q;
	logic [23:0]      ddig_q;
	logic [CNT_W-1:0] cnt_q;
	logic             first_pend_q;

	// sequencer
	state_t state_q, state_d;
	logic [11:0] yr_q;
	logic [6:0]  mon_q;
	logic [3:0]  mo_q;
	logic [4:0]  day_q;
	logic [6:0]  dd_q;
	logic [6:0]  sec_q;
	logic [6:0]  min_q;
	logic [6:0]  hr_q;
	logic [2:0]  dadd_q;
	logic [6:0]  walk_q;
	logic [16:0] lt_q;
	logic [32:0] acc_q;
	logic [1:0]  mac_q;
	logic [31:0] now_q;
	status_t     cls_q;
	logic        led_q;
	logic        scok_q;

	// result register
	logic        out_valid_q;
	status_t     o_status_q;
	logic        o_led_q;
	logic [11:0] o_year_q;
	logic [3:0]  o_month_q;
	logic [4:0]  o_day_q;
	logic [4:0]  o_hour_q;
	logic [5:0]  o_min_q;
	logic [5:0]  o_sec_q;
	logic        o_set_q;
	logic        o_save_q;

	logic in_acc, byte_acc, eoc_acc, cfg_wr, out_load;
	logic [3:0] b_nib;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign byte_acc = in_acc && !req_type && (cnt_q < CNT_W'(CHUNK_BYTES));
	assign eoc_acc  = in_acc && req_type;
	assign b_nib    = nib(data_byte);

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[3:2])
			REG_ZONE:   prdata = {28'b0, zone_q};
			REG_DRIFT:  prdata = {24'b0, drift_q};
			REG_MINLEN: prdata = {24'b0, minlen_q};
			default:    prdata = 32'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q   <= 4'd8;
			drift_q  <= 8'd2;
			minlen_q <= 8'd68;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_ZONE:   zone_q   <= pwdata[3:0];
				REG_DRIFT:  drift_q  <= pwdata[7:0];
				REG_MINLEN: minlen_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// ---------------- byte scanner ----------------
	// Before the match every byte enters the tail window; after it, bytes up
	// to the first star do. The window keeps digit values, with 15 for any other character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_q   <= 3'd0;
			found_q  <= 1'b0;
			off_q    <= 12'd0;
			tdig_q   <= 24'd0;
			stchar_q <= 8'd0;
			star_q   <= 1'b0;
			pos_ok_q <= 1'b0;
			ddig_q   <= 24'd0;
			cnt_q    <= '0;
			for (int i = 0; i < DATE_BACKOFF; i++)
				tail_q[i] <= 4'd0;
		end else if (eoc_acc) begin
			prog_q   <= 3'd0;
			found_q  <= 1'b0;
			off_q    <= 12'd0;
			tdig_q   <= 24'd0;
			stchar_q <= 8'd0;
			star_q   <= 1'b0;
			pos_ok_q <= 1'b0;
			ddig_q   <= 24'd0;
			cnt_q    <= '0;
			for (int i = 0; i < DATE_BACKOFF; i++)
				tail_q[i] <= 4'd0;
		end else if (byte_acc) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (!found_q) begin
				for (int i = 0; i < DATE_BACKOFF - 1; i++)
					tail_q[i] <= tail_q[i+1];
				tail_q[DATE_BACKOFF-1] <= b_nib;
				if (data_byte == pat_char(prog_q)) begin
					if (prog_q == 3'd4) begin
						found_q <= 1'b1;
						prog_q  <= 3'd0;
						off_q   <= 12'd5;
					end else begin
						prog_q <= prog_q + 3'd1;
					end
				end else begin
					prog_q <= (data_byte == "G") ? 3'd1 : 3'd0;
				end
			end else begin
				if (!star_q) begin
					if (data_byte == "*") begin
						star_q   <= 1'b1;
						pos_ok_q <= (off_q >= 12'(DATE_BACKOFF + 1));
						ddig_q   <= {tail_q[0], tail_q[1], tail_q[2],
						             tail_q[3], tail_q[4], tail_q[5]};
					end else begin
						for (int i = 0; i < DATE_BACKOFF - 1; i++)
							tail_q[i] <= tail_q[i+1];
						tail_q[DATE_BACKOFF-1] <= b_nib;
					end
				end
				for (int k = 0; k < 6; k++) begin
					if (off_q == 12'(6 + k))
						tdig_q[23-4*k -: 4] <= b_nib;
				end
				if (off_q == 12'd16)
					stchar_q <= data_byte;
				if (off_q < OFFSET_MAX)
					off_q <= off_q + 12'd1;
			end
		end
	end

	// ---------------- shared compare/subtract unit ----------------
	logic [6:0] su_a, su_k, su_d;
	logic       su_ge;

	always_comb begin
		unique case (state_q)
			S_SEC:   begin su_a = sec_q; su_k = 7'd60; end
			S_MIN:   begin su_a = min_q; su_k = 7'd60; end
			S_HR:    begin su_a = hr_q;  su_k = 7'd24; end
			default: begin su_a = mon_q; su_k = 7'd12; end
		endcase
		su_ge = (su_a >= su_k);
		su_d  = su_a - su_k;
	end

	// multiply-accumulate for the epoch seconds: day*24+h, *60+m, *60+s
	logic [5:0] mac_k;
	logic [6:0] mac_v;
	always_comb begin
		case (mac_q)
			2'd0:    begin mac_k = 6'd24; mac_v = hr_q;  end
			2'd1:    begin mac_k = 6'd60; mac_v = min_q; end
			default: begin mac_k = 6'd60; mac_v = sec_q; end
		endcase
	end

	// drift compare
	logic signed [34:0] diff;
	logic [34:0]        diff_mag;
	logic               drift_hit;
	assign diff      = $signed({3'b0, now_q}) - $signed({2'b0, acc_q});
	assign diff_mag  = diff[34] ? 35'(-diff) : 35'(diff);
	assign drift_hit = (diff_mag >= 35'(drift_q));

	// pairs at the end of a chunk
	logic [6:0] p_dd, p_mo, p_yy, p_hh, p_mi, p_ss;
	assign p_dd = pair_val(ddig_q[23:20], ddig_q[19:16]);
	assign p_mo = pair_val(ddig_q[15:12], ddig_q[11:8]);
	assign p_yy = pair_val(ddig_q[7:4],   ddig_q[3:0]);
	assign p_hh = pair_val(tdig_q[23:20], tdig_q[19:16]);
	assign p_mi = pair_val(tdig_q[15:12], tdig_q[11:8]);
	assign p_ss = pair_val(tdig_q[7:4],   tdig_q[3:0]);

	logic       len_ok;
	logic [3:0] m1;
	logic [4:0] cur_dim;
	assign len_ok  = found_q && (off_q >= {4'b0, minlen_q});
	assign m1      = mon_q[3:0] + 4'd1;
	assign cur_dim = dim(yr_q, mo_q);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (eoc_acc)
					state_d = (len_ok && star_q && pos_ok_q) ? S_MON : S_DONE;
			end
			S_MON:  if (!su_ge) state_d = S_SEC;
			S_SEC:  if (!su_ge) state_d = S_MIN;
			S_MIN:  if (!su_ge) state_d = S_HR;
			S_HR:   if (!su_ge) state_d = S_BASE;
			S_BASE: state_d = S_WALK;
			S_WALK: if (walk_q == 7'd0) state_d = S_MAC;
			S_MAC:  if (mac_q == 2'd2) state_d = S_CMP;
			S_CMP:  state_d = S_DONE;
			S_DONE: if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// ---------------- sequencer datapath ----------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (eoc_acc) begin
					now_q  <= now_seconds;
					led_q  <= len_ok;
					scok_q <= (stchar_q == "A") || (stchar_q == "V");
					cls_q  <= !len_ok ? ST_NONE : ST_NOSTAR;
					dd_q   <= p_dd;
					sec_q  <= p_ss;
					min_q  <= p_mi;
					hr_q   <= p_hh + {3'b0, zone_q};
					dadd_q <= 3'd0;
					mac_q  <= 2'd0;
					// month zero means December of the year before
					if (p_mo == 7'd0) begin
						yr_q  <= YEAR_BASE + 12'(p_yy) - 12'd1;
						mon_q <= 7'd11;
					end else begin
						yr_q  <= YEAR_BASE + 12'(p_yy);
						mon_q <= p_mo - 7'd1;
					end
				end
			end
			S_MON: begin
				if (su_ge) begin
					mon_q <= su_d;
					yr_q  <= yr_q + 12'd1;
				end
			end
			S_SEC: begin
				if (su_ge) begin
					sec_q <= su_d;
					min_q <= min_q + 7'd1;
				end
			end
			S_MIN: begin
				if (su_ge) begin
					min_q <= su_d;
					hr_q  <= hr_q + 7'd1;
				end
			end
			S_HR: begin
				if (su_ge) begin
					hr_q   <= su_d;
					dadd_q <= dadd_q + 3'd1;
				end
			end
			S_BASE: begin
				// start one day before the first of the month, then walk forward
				lt_q <= jan1_days(yr_q) + 17'(cum_days(yr_q, m1)) - 17'd1
				        + 17'(dd_q) + 17'(dadd_q);
				walk_q <= dd_q + 7'(dadd_q);
				if (m1 == 4'd1) begin
					yr_q  <= yr_q - 12'd1;
					mo_q  <= 4'd12;
					day_q <= 5'd31;
				end else begin
					mo_q  <= m1 - 4'd1;
					day_q <= dim(yr_q, m1 - 4'd1);
				end
			end
			S_WALK: begin
				if (walk_q == 7'd0) begin
					acc_q <= 33'(lt_q);
				end else begin
					walk_q <= walk_q - 7'd1;
					if (day_q == cur_dim) begin
						day_q <= 5'd1;
						if (mo_q == 4'd12) begin
							mo_q <= 4'd1;
							yr_q <= yr_q + 12'd1;
						end else begin
							mo_q <= mo_q + 4'd1;
						end
					end else begin
						day_q <= day_q + 5'd1;
					end
				end
			end
			S_MAC: begin
				acc_q <= 33'(acc_q * {27'b0, mac_k}) + 33'(mac_v);
				mac_q <= mac_q + 2'd1;
			end
			S_CMP: begin
				if (!scok_q)
					cls_q <= ST_BADSTAT;
				else if (drift_hit)
					cls_q <= ST_SET;
				else
					cls_q <= ST_SYNC;
			end
			S_DONE: ;
			default: ;
		endcase
	end

	// ---------------- result register ----------------
	logic res_time, res_set;
	assign res_time = (cls_q != ST_NONE) && (cls_q != ST_NOSTAR);
	assign res_set  = (cls_q == ST_SET);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			first_pend_q <= 1'b1;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			if (res_set)
				first_pend_q <= 1'b0;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_status_q <= cls_q;
			o_led_q    <= led_q;
			o_year_q   <= res_time ? yr_q : 12'd0;
			o_month_q  <= res_time ? mo_q : 4'd0;
			o_day_q    <= res_time ? day_q : 5'd0;
			o_hour_q   <= res_time ? hr_q[4:0] : 5'd0;
			o_min_q    <= res_time ? min_q[5:0] : 6'd0;
			o_sec_q    <= res_time ? sec_q[5:0] : 6'd0;
			o_set_q    <= res_set;
			o_save_q   <= res_set && first_pend_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = o_status_q;
	assign led_lit       = o_led_q;
	assign local_year    = o_year_q;
	assign local_month   = o_month_q;
	assign local_day     = o_day_q;
	assign local_hour    = o_hour_q;
	assign local_minute  = o_min_q;
	assign local_second  = o_sec_q;
	assign set_clock     = o_set_q;
	assign save_hw_clock = o_save_q;

	// ---------------- assertions ----------------
	a_set_matches_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (set_clock == (status == ST_SET)))
		else $error("set_clock disagrees with status");

	a_save_needs_set: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && save_hw_clock) |-> set_clock)
		else $error("hardware-clock save without clock set");

	a_eoc_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		eoc_acc |=> in_stall)
		else $error("input taken while chunk is evaluated");

	a_save_once: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && save_hw_clock) |-> !first_pend_q)
		else $error("first-set flag still pending after save");

endmodule
